// File: design/ecs_pkg.sv
// Shared types and constants for the encoder clock setter.
package ecs_pkg;

   localparam int unsigned PHASE_W = 2;

   // Phase at which a step is counted, and the prior phase that means up.
   localparam logic [PHASE_W-1:0] PHASE_ARRIVE  = 2'b11;
   localparam logic [PHASE_W-1:0] PHASE_UP_FROM = 2'b01;

   // Largest hour and minute values before wrapping.
   localparam logic [4:0] HOURS_MAX   = 5'd23;
   localparam logic [5:0] MINUTES_MAX = 6'd59;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   typedef struct packed {
      logic [3:0] encoder_phases;
      logic       adjust_alarm;
   } req_type;

   typedef struct packed {
      logic [4:0] clock_hours;
      logic [5:0] clock_minutes;
      logic [4:0] alarm_hours;
      logic [5:0] alarm_minutes;
      step_type   hour_step;
      step_type   minute_step;
   } rsp_type;

endpackage

// File: design/ecs_step_detect.sv
// Step detector for one quadrature encoder, with its last-phase register.
module ecs_step_detect (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [ecs_pkg::PHASE_W-1:0]  phase,
   output ecs_pkg::step_type            step
);
   import ecs_pkg::*;

   logic [PHASE_W-1:0] last_phase_ff;
   logic [PHASE_W-1:0] last_phase_in;

   always_comb begin
      step = STEP_NONE;
      if (phase == PHASE_ARRIVE && last_phase_ff != PHASE_ARRIVE) begin
         step = (last_phase_ff == PHASE_UP_FROM) ? STEP_UP : STEP_DOWN;
      end
      last_phase_in = advance ? phase : last_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= PHASE_ARRIVE;
      end else begin
         last_phase_ff <= last_phase_in;
      end
   end

endmodule

// File: design/ecs_time_set.sv
// Clock and alarm hour/minute counters with modular up/down stepping.
module ecs_time_set (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              adjust_alarm,
   input  ecs_pkg::step_type hour_step,
   input  ecs_pkg::step_type minute_step,
   output logic [4:0]        clock_hours,
   output logic [5:0]        clock_minutes,
   output logic [4:0]        alarm_hours,
   output logic [5:0]        alarm_minutes
);
   import ecs_pkg::*;

   logic [4:0] clock_hour_ff,   clock_hour_in;
   logic [5:0] clock_minute_ff, clock_minute_in;
   logic [4:0] alarm_hour_ff,   alarm_hour_in;
   logic [5:0] alarm_minute_ff, alarm_minute_in;
   logic [4:0] hour_sel,   hour_next;
   logic [5:0] minute_sel, minute_next;

   function automatic logic [4:0] hour_step_fn(input logic [4:0] value, input step_type step);
      logic [4:0] result;
      result = value;
      unique case (step)
         STEP_UP:   result = (value >= HOURS_MAX) ? 5'd0 : value + 5'd1;
         STEP_DOWN: result = (value == 5'd0) ? HOURS_MAX : value - 5'd1;
         default:   result = value;
      endcase
      return result;
   endfunction

   function automatic logic [5:0] minute_step_fn(input logic [5:0] value,
                                                 input step_type step);
      logic [5:0] result;
      result = value;
      unique case (step)
         STEP_UP:   result = (value >= MINUTES_MAX) ? 6'd0 : value + 6'd1;
         STEP_DOWN: result = (value == 6'd0) ? MINUTES_MAX : value - 6'd1;
         default:   result = value;
      endcase
      return result;
   endfunction

   always_comb begin
      hour_sel    = adjust_alarm ? alarm_hour_ff : clock_hour_ff;
      minute_sel  = adjust_alarm ? alarm_minute_ff : clock_minute_ff;
      hour_next   = hour_step_fn(hour_sel, hour_step);
      minute_next = minute_step_fn(minute_sel, minute_step);

      // Only the selected set moves; the other holds.
      clock_hour_in   = clock_hour_ff;
      clock_minute_in = clock_minute_ff;
      alarm_hour_in   = alarm_hour_ff;
      alarm_minute_in = alarm_minute_ff;
      if (adjust_alarm) begin
         alarm_hour_in   = hour_next;
         alarm_minute_in = minute_next;
      end else begin
         clock_hour_in   = hour_next;
         clock_minute_in = minute_next;
      end

      clock_hours   = clock_hour_in;
      clock_minutes = clock_minute_in;
      alarm_hours   = alarm_hour_in;
      alarm_minutes = alarm_minute_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hour_ff   <= '0;
         clock_minute_ff <= '0;
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
      end else if (advance) begin
         clock_hour_ff   <= clock_hour_in;
         clock_minute_ff <= clock_minute_in;
         alarm_hour_ff   <= alarm_hour_in;
         alarm_minute_ff <= alarm_minute_in;
      end
   end

endmodule

// File: design/encoder_clock_setter_top.sv
// Encoder clock setter top level: input register, step and time logic, result register.
//
// Each request carries the phases of two quadrature encoders and a clock/alarm
// select; each yields exactly one response with the four time fields after the
// request and the step seen on each encoder. A step counts only on arrival at
// phase 11 (from 01 up, from 00 or 10 down); the hour encoder wraps mod 24 and
// the minute encoder mod 60 in the selected set. One request is taken per clock while
// the response is not stalled; each passes the input register, then the response
// register; the time counters and last phases are read and written between the two.
module encoder_clock_setter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ecs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ecs_pkg::rsp_type rsp_payload
);
   import ecs_pkg::*;

   logic     req_valid_ff, req_valid_in;
   req_type  req_data_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff,  rsp_data_in;
   logic     out_free;
   logic     advance;
   step_type hour_step;
   step_type minute_step;
   logic [4:0] clock_hours, alarm_hours;
   logic [5:0] clock_minutes, alarm_minutes;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   ecs_step_detect u_hour_detect (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .phase   (req_data_ff.encoder_phases[1:0]),
      .step    (hour_step)
   );

   ecs_step_detect u_minute_detect (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .phase   (req_data_ff.encoder_phases[3:2]),
      .step    (minute_step)
   );

   ecs_time_set u_time_set (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .adjust_alarm  (req_data_ff.adjust_alarm),
      .hour_step     (hour_step),
      .minute_step   (minute_step),
      .clock_hours   (clock_hours),
      .clock_minutes (clock_minutes),
      .alarm_hours   (alarm_hours),
      .alarm_minutes (alarm_minutes)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = req_valid_ff;
      end
      rsp_data_in.clock_hours   = clock_hours;
      rsp_data_in.clock_minutes = clock_minutes;
      rsp_data_in.alarm_hours   = alarm_hours;
      rsp_data_in.alarm_minutes = alarm_minutes;
      rsp_data_in.hour_step     = hour_step;
      rsp_data_in.minute_step   = minute_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // Hold the request while stalled, take a new one otherwise.
      if (!req_stall) begin
         req_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.clock_hours < 5'd24 && rsp_payload.alarm_hours < 5'd24 &&
                     rsp_payload.clock_minutes < 6'd60 && rsp_payload.alarm_minutes < 6'd60))
      else $error("response time field out of range");

   a_advance_delivers: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request not presented as response");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while both stages are full");

   a_step_arrive: assert property (@(posedge clock) disable iff (reset)
      (advance && hour_step != STEP_NONE) |-> req_data_ff.encoder_phases[1:0] == PHASE_ARRIVE)
      else $error("hour step without arrival at phase 11");

endmodule
